>>> rtl/stxr_pkg.sv
// shared types and constants of the stx/etx status frame receiver
// no dependencies; used by every module of the block

package stxr_pkg;

   // frame layout
   localparam logic [7:0] STX_BYTE       = 8'h02;
   localparam logic [7:0] ETX_BYTE       = 8'h03;
   localparam logic [4:0] POS_HUNT       = 5'd0;
   localparam logic [4:0] POS_BOARD      = 5'd1;
   localparam logic [4:0] POS_DATA_FIRST = 5'd4;
   localparam logic [4:0] POS_ETX        = 5'd28;
   localparam logic [4:0] POS_BCC        = 5'd29;

   // channel records held per frame
   localparam int FRAME_CHANNELS = 8;
   localparam int CH_IDX_W       = 3;

   // byte within a channel's three-byte group
   localparam logic [1:0] SUB_STATE = 2'd0;
   localparam logic [1:0] SUB_HIGH  = 2'd1;
   localparam logic [1:0] SUB_LOW   = 2'd2;

   // register map
   localparam logic REG_VOLTAGE = 1'b0;
   localparam logic [7:0] VOLTAGE_RESET = 8'd220;

   // finished frame handed from front to back
   typedef struct packed {
      logic       bad;
      logic [7:0] node_id;
   } frame_desc_type;

   // one channel record read by the back part
   typedef struct packed {
      logic        switched_on;
      logic [15:0] current_ma;
   } chan_rec_type;

endpackage

>>> rtl/stxr_front.sv
// front part: hunts for the start byte, collects the frame, checks end and check bytes
// holds two banks of channel records; depends on stxr_pkg

module stxr_front
   import stxr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                q_full,
   output logic                q_push,
   output frame_desc_type      q_push_desc,
   input  logic                rd_bank,
   input  logic [CH_IDX_W-1:0] rd_ch,
   output chan_rec_type        rd_rec
);

   logic [4:0]          pos_ff, pos_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          board_ff, board_in;
   logic                etx_ok_ff, etx_ok_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;
   logic [1:0]          sub_ff, sub_in;
   logic                bank_ff, bank_in;
   logic                accept;
   logic                data_we;

   // channel record banks, one per frame in flight
   logic                on_ff [2][FRAME_CHANNELS];
   logic [7:0]          hi_ff [2][FRAME_CHANNELS];
   logic [7:0]          lo_ff [2][FRAME_CHANNELS];

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // byte classification and frame bookkeeping
   always_comb begin
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      board_in    = board_ff;
      etx_ok_in   = etx_ok_ff;
      ch_in       = ch_ff;
      sub_in      = sub_ff;
      bank_in     = bank_ff;
      data_we     = 1'b0;
      q_push      = 1'b0;
      q_push_desc = '{bad: (!etx_ok_ff) || (req_rx_byte != xor_ff), node_id: board_ff};
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_rx_byte == STX_BYTE) begin
               pos_in = POS_BOARD;
               xor_in = req_rx_byte;
               ch_in  = '0;
               sub_in = SUB_STATE;
            end
         end else if (pos_ff < POS_BCC) begin
            xor_in = xor_ff ^ req_rx_byte;
            pos_in = pos_ff + 5'd1;
            if (pos_ff == POS_BOARD) begin
               board_in = req_rx_byte;
            end
            if (pos_ff == POS_ETX) begin
               etx_ok_in = (req_rx_byte == ETX_BYTE);
            end
            if (pos_ff >= POS_DATA_FIRST && pos_ff < POS_ETX) begin
               data_we = 1'b1;
               if (sub_ff == SUB_LOW) begin
                  sub_in = SUB_STATE;
                  ch_in  = ch_ff + 1'b1;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end else begin
            // check byte closes the frame
            q_push  = 1'b1;
            pos_in  = POS_HUNT;
            xor_in  = '0;
            bank_in = !bank_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         xor_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         xor_ff  <= xor_in;
         bank_ff <= bank_in;
      end
   end

   // frame payload registers
   always_ff @(posedge clock) begin
      board_ff  <= board_in;
      etx_ok_ff <= etx_ok_in;
      ch_ff     <= ch_in;
      sub_ff    <= sub_in;
   end

   // channel record writes
   always_ff @(posedge clock) begin
      if (data_we) begin
         case (sub_ff)
            SUB_STATE: on_ff[bank_ff][ch_ff] <= req_rx_byte[0];
            SUB_HIGH:  hi_ff[bank_ff][ch_ff] <= req_rx_byte;
            default:   lo_ff[bank_ff][ch_ff] <= req_rx_byte;
         endcase
      end
   end

   // read port for the back part
   assign rd_rec = '{switched_on: on_ff[rd_bank][rd_ch],
                     current_ma: {hi_ff[rd_bank][rd_ch], lo_ff[rd_bank][rd_ch]}};

endmodule

>>> rtl/stxr_queue.sv
// two-entry queue of finished frame descriptors between front and back
// depends on stxr_pkg

module stxr_queue
   import stxr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output frame_desc_type head
);

   frame_desc_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

>>> rtl/stxr_back.sv
// back part: walks the channels of a good frame, or gives one error beat for a bad one
// fills the result register from the front banks' channel records; depends on stxr_pkg

module stxr_back
   import stxr_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          voltage,
   input  logic                q_not_empty,
   input  frame_desc_type      q_head,
   output logic                q_pop,
   output logic                rd_bank,
   output logic [CH_IDX_W-1:0] rd_ch,
   input  chan_rec_type        rd_rec,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_channel_number,
   output logic [7:0]          rsp_node_id,
   output logic                rsp_switched_on,
   output logic [15:0]         rsp_current_ma,
   output logic [23:0]         rsp_power_mw,
   output logic                rsp_frame_status,
   output logic                rsp_last_of_frame
);

   localparam int NCH = (CHANNELS > FRAME_CHANNELS) ? FRAME_CHANNELS : CHANNELS;
   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NCH - 1);

   logic                bank_ff, bank_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;
   logic                valid_ff, valid_in;
   logic                load;
   logic                last_ch;

   logic [3:0]  chnum_ff;
   logic [7:0]  board_ff;
   logic        on_ff;
   logic [15:0] ma_ff;
   logic [23:0] mw_ff;
   logic        status_ff;
   logic        last_ff;

   assign rd_bank = bank_ff;
   assign rd_ch   = ch_ff;
   assign load    = q_not_empty && (!valid_ff || rsp_ready);
   assign last_ch = (ch_ff == LAST_CH);
   assign q_pop   = load && (q_head.bad || last_ch);

   // channel walk and frame release
   always_comb begin
      bank_in  = bank_ff;
      ch_in    = ch_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (q_pop) begin
            ch_in   = '0;
            bank_in = !bank_ff;
         end else begin
            ch_in = ch_ff + 1'b1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         ch_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         bank_ff  <= bank_in;
         ch_ff    <= ch_in;
         valid_ff <= valid_in;
      end
   end

   // result register, power product registered here
   always_ff @(posedge clock) begin
      if (load) begin
         if (q_head.bad) begin
            chnum_ff  <= '0;
            board_ff  <= '0;
            on_ff     <= 1'b0;
            ma_ff     <= '0;
            mw_ff     <= '0;
            status_ff <= 1'b1;
            last_ff   <= 1'b1;
         end else begin
            chnum_ff  <= 4'({1'b0, ch_ff}) + 4'd1;
            board_ff  <= q_head.node_id;
            on_ff     <= rd_rec.switched_on;
            ma_ff     <= rd_rec.current_ma;
            mw_ff     <= 24'(voltage) * 24'(rd_rec.current_ma);
            status_ff <= 1'b0;
            last_ff   <= last_ch;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_channel_number = chnum_ff;
   assign rsp_node_id        = board_ff;
   assign rsp_switched_on    = on_ff;
   assign rsp_current_ma     = ma_ff;
   assign rsp_power_mw       = mw_ff;
   assign rsp_frame_status   = status_ff;
   assign rsp_last_of_frame  = last_ff;

endmodule

>>> rtl/stx_etx_bcc_status_frame_receiver.sv
// top level of the stx/etx status frame receiver: front, descriptor queue, back, csr
// depends on stxr_pkg, stxr_front, stxr_queue, stxr_back
//
//   channel   direction   ports
//   req       in          req_valid, req_ready, req_rx_byte
//   rsp       out         rsp_valid, rsp_ready, rsp_* result fields
//   csr       in/out      apb port, csr_psel through csr_pready
//
// the front takes one byte a cycle unless the queue is full; a good frame gives
// min(CHANNELS, 8) result beats, one a cycle unless rsp_ready stalls the back.
// two channel banks and a two-entry queue let the front collect the next frame
// while the back drains; the front stalls only when both banks hold frames.
// a bad frame gives one error beat; results pass the queue and the result register.
// synchronous active-high reset clears control state and sets voltage to 220.

module stx_etx_bcc_status_frame_receiver
   import stxr_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_channel_number,
   output logic [7:0]  rsp_node_id,
   output logic        rsp_switched_on,
   output logic [15:0] rsp_current_ma,
   output logic [23:0] rsp_power_mw,
   output logic        rsp_frame_status,
   output logic        rsp_last_of_frame,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]          voltage_ff;
   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_not_empty;
   frame_desc_type      q_push_desc;
   frame_desc_type      q_head;
   logic                rd_bank;
   logic [CH_IDX_W-1:0] rd_ch;
   chan_rec_type        rd_rec;

   // configuration register
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_ff <= VOLTAGE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_VOLTAGE) begin
         voltage_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_VOLTAGE) ? {24'd0, voltage_ff} : 32'd0;

   stxr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_desc (q_push_desc),
      .rd_bank     (rd_bank),
      .rd_ch       (rd_ch),
      .rd_rec      (rd_rec)
   );

   stxr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   stxr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .voltage            (voltage_ff),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rd_bank            (rd_bank),
      .rd_ch              (rd_ch),
      .rd_rec             (rd_rec),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel_number (rsp_channel_number),
      .rsp_node_id        (rsp_node_id),
      .rsp_switched_on    (rsp_switched_on),
      .rsp_current_ma     (rsp_current_ma),
      .rsp_power_mw       (rsp_power_mw),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule
